FILE: sv/dms_pkg.sv
// ---------------------------------------------------------------------------
// dms_pkg
// shared widths and constants for the angle to degrees, minutes, seconds block
// ---------------------------------------------------------------------------
package dms_pkg;

  localparam int ANGLE_W   = 31;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;

  localparam int DEG_W     = 9;
  localparam int MAG_W     = 8;
  localparam int MIN_W     = 6;
  localparam int SEC_W     = 6;
  localparam int FOLD_W    = 9;

  localparam int HALF_TURN = 180;
  localparam int FULL_TURN = 360;

  localparam logic [MAG_W-1:0]  HALF_TURN_MAG  = 8'd180;
  localparam logic [MAG_W-1:0]  HALF_TURN_LESS = 8'd179;
  localparam logic [FOLD_W-1:0] HALF_TURN_FOLD = 9'd180;
  localparam logic [FOLD_W-1:0] FULL_TURN_FOLD = 9'd360;
  localparam logic [SEC_W-1:0]  ARC_WRAP       = 6'd60;

endpackage

FILE: sv/decimal_angle_to_dms.sv
// ---------------------------------------------------------------------------
// decimal_angle_to_dms
// folds a fixed-point angle to -180..180 and splits it into degrees, minutes
// and rounded seconds of arc
// ---------------------------------------------------------------------------
// channel  dir  tdata fields (lsb first)
// s_*      in   angle[30:0], bit 31 unused
// m_*      out  whole_degrees[8:0], arc_minutes[14:9], arc_seconds[20:15],
//               is_negative[21], bits 23:22 zero
//
// one word per cycle sustained while the sink is ready
// six pipeline stages and an output register, each with its own valid bit
// a stage moves on when it is empty or the stage after it moves on
// the deepest path is the reciprocal multiply of the mod 360 fold
// rst clears the valid bits only
// ---------------------------------------------------------------------------
module decimal_angle_to_dms
  import dms_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // angle
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // whole_degrees, arc_minutes, arc_seconds, is_negative
);

  localparam int IW    = (FRAC_BITS >= 30) ? 2 : ANGLE_W - FRAC_BITS;
  localparam int UW    = IW + 10;
  localparam int VW    = UW - 3;
  localparam int SH    = VW + 6;
  localparam int MW    = SH - 5;
  localparam int PW    = VW + MW;
  localparam int QW    = PW - SH;
  localparam int NSTG  = 6;
  localparam longint OFFS  = 360 * ((2 ** (IW - 1) + 359) / 360);
  localparam longint RECIP = ((64'sd1 <<< SH) + 44) / 45;
  localparam logic [MW-1:0]  RECIP_M = RECIP[MW-1:0];
  localparam logic [63:0]    U_BIAS  = 64'(HALF_TURN + OFFS);

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   en;

  // stage payloads
  logic [UW-1:0]        s1_u;
  logic [FRAC_BITS-1:0] s1_f;
  logic [PW-1:0]        s2_p;
  logic [VW-1:0]        s2_v;
  logic [2:0]           s2_lo;
  logic [FRAC_BITS-1:0] s2_f;
  logic [FOLD_W-1:0]    s3_fi;
  logic [FRAC_BITS-1:0] s3_f;
  logic [MAG_W-1:0]     s4_deg;
  logic [FRAC_BITS-1:0] s4_frac;
  logic                 s4_neg;
  logic [MAG_W-1:0]     s5_deg;
  logic                 s5_neg;
  logic [MIN_W-1:0]     s5_min;
  logic [FRAC_BITS-1:0] s5_frac;
  logic [MAG_W-1:0]     s6_deg;
  logic                 s6_neg;
  logic [MIN_W-1:0]     s6_min;
  logic [SEC_W-1:0]     s6_sec;
  logic                 s6_rnd;

  // combinational next values
  logic signed [63:0]   a_ext;
  logic signed [63:0]   a_shr;
  logic [63:0]          u_full;
  logic [UW-1:0]        u_next;
  logic [VW-1:0]        v_next;
  logic [PW-1:0]        p_next;
  logic [QW-1:0]        q;
  logic [VW-1:0]        r;
  logic [FOLD_W-1:0]    fi_next;
  logic [MAG_W-1:0]     deg_next;
  logic [FRAC_BITS-1:0] frac_next;
  logic                 neg_next;
  logic [FRAC_BITS+5:0] t1;
  logic [FRAC_BITS+5:0] t2;
  logic [SEC_W-1:0]     sec_up;
  logic [SEC_W-1:0]     sec_fin;
  logic [MIN_W-1:0]     min_up;
  logic [MIN_W-1:0]     min_fin;
  logic [MAG_W-1:0]     deg_fin;
  logic [DEG_W-1:0]     sdeg;

  // handshake chain
  always_comb begin
    en[NSTG] = !m_tvalid || m_tready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_tready = en[0];

  // integer part plus a half turn, biased by a multiple of 360 to stay non-negative
  assign a_ext  = {{33{s_tdata[ANGLE_W-1]}}, s_tdata[ANGLE_W-1:0]};
  assign a_shr  = a_ext >>> FRAC_BITS;
  assign u_full = 64'(a_shr) + U_BIAS;
  assign u_next = u_full[UW-1:0];

  // mod 360 as mod 45 on u/8, by reciprocal
  assign v_next = s1_u[UW-1:3];
  assign p_next = PW'(v_next) * PW'(RECIP_M);
  assign q      = s2_p[PW-1:SH];
  assign r      = s2_v - VW'(VW'(q) * VW'(45));
  assign fi_next = {r[5:0], s2_lo};

  // fi = folded integer part + 180
  always_comb begin
    if (s3_fi >= HALF_TURN_FOLD) begin
      deg_next  = MAG_W'(s3_fi - HALF_TURN_FOLD);
      frac_next = s3_f;
      neg_next  = 1'b0;
    end else if (s3_f == '0) begin
      deg_next  = MAG_W'(HALF_TURN_FOLD - s3_fi);
      frac_next = '0;
      neg_next  = (s3_fi != '0);
    end else begin
      deg_next  = HALF_TURN_LESS - MAG_W'(s3_fi);
      frac_next = '0 - s3_f;
      neg_next  = 1'b1;
    end
  end

  assign t1 = {s4_frac, 6'b0} - {4'b0, s4_frac, 2'b0};
  assign t2 = {s5_frac, 6'b0} - {4'b0, s5_frac, 2'b0};

  // round to nearest, half up, with carry
  always_comb begin
    sec_up  = s6_sec + SEC_W'(1);
    min_up  = s6_min + MIN_W'(1);
    sec_fin = s6_sec;
    min_fin = s6_min;
    deg_fin = s6_deg;
    if (s6_rnd) begin
      if (sec_up == ARC_WRAP) begin
        sec_fin = '0;
        if (min_up == ARC_WRAP) begin
          min_fin = '0;
          deg_fin = s6_deg + MAG_W'(1);
        end else begin
          min_fin = min_up;
        end
      end else begin
        sec_fin = sec_up;
      end
    end
    sdeg = s6_neg ? (DEG_W'(0) - {1'b0, deg_fin}) : {1'b0, deg_fin};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
      if (en[NSTG]) m_tvalid <= vld[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_u <= u_next;
      s1_f <= a_ext[FRAC_BITS-1:0];
    end
    if (en[1]) begin
      s2_p  <= p_next;
      s2_v  <= v_next;
      s2_lo <= s1_u[2:0];
      s2_f  <= s1_f;
    end
    if (en[2]) begin
      s3_fi <= fi_next;
      s3_f  <= s2_f;
    end
    if (en[3]) begin
      s4_deg  <= deg_next;
      s4_frac <= frac_next;
      s4_neg  <= neg_next;
    end
    if (en[4]) begin
      s5_deg  <= s4_deg;
      s5_neg  <= s4_neg;
      s5_min  <= t1[FRAC_BITS+5:FRAC_BITS];
      s5_frac <= t1[FRAC_BITS-1:0];
    end
    if (en[5]) begin
      s6_deg <= s5_deg;
      s6_neg <= s5_neg;
      s6_min <= s5_min;
      s6_sec <= t2[FRAC_BITS+5:FRAC_BITS];
      s6_rnd <= t2[FRAC_BITS-1];
    end
    if (en[NSTG]) begin
      m_tdata <= {2'b00, s6_neg, sec_fin, min_fin, sdeg};
    end
  end

  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (&vld) && m_tvalid && !m_tready)
    else $error("input stalled while the pipeline has room");

  a_fold_range : assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> s3_fi < FULL_TURN_FOLD)
    else $error("fold residue out of range");

  a_mag_range : assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> s4_deg <= HALF_TURN_MAG)
    else $error("magnitude degrees above a half turn");

  a_stage_hold : assert property (@(posedge clk) disable iff (rst)
    vld[4] && !en[4] |=> vld[4] && $stable(s5_min) && $stable(s5_frac))
    else $error("stalled stage lost its word");

endmodule

FILE: dv/decimal_angle_to_dms_test.sv
// ---------------------------------------------------------------------------
// decimal_angle_to_dms_test
// self-checking bench for the angle to degrees, minutes, seconds block:
// a directed set of edge angles then random angles, sent in bursts against
// a stalling sink with long hold-offs, every output word checked in order
// against a fixed-point model of the fold, split and rounding
// ---------------------------------------------------------------------------
module decimal_angle_to_dms_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dms_pkg::*;

  localparam int     FRAC_BITS   = 20;
  localparam longint ONE         = longint'(1) << FRAC_BITS;
  localparam int     N_RANDOM    = 550;
  localparam int     HOLD_CYCLES = 60;
  localparam int     CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [DEG_W-1:0] whole_degrees;
    logic [MIN_W-1:0]        arc_minutes;
    logic [SEC_W-1:0]        arc_seconds;
    logic                    is_negative;
  } dms_t;

  class dms_tracker;
    dms_t pending_dms[$];
    int   errors;
    int   words_checked;
    int   angles_noted;

    function dms_t fold_and_split(logic [ANGLE_W-1:0] angle);
      longint          mask, half_turn, full_turn, a, folded, sdeg;
      longint unsigned mag, deg, t, mins, secs, fr;
      bit              neg;
      dms_t            r;
      mask      = ONE - 1;
      half_turn = longint'(HALF_TURN) * ONE;
      full_turn = longint'(FULL_TURN) * ONE;
      a = longint'($signed(angle));
      if (a >= 0) begin
        folded = (a + half_turn) % full_turn - half_turn;
      end else begin
        folded = (a - half_turn) % full_turn + half_turn;
      end
      neg  = (folded < 0) && (folded != -half_turn);
      mag  = (folded < 0) ? -folded : folded;
      deg  = mag >> FRAC_BITS;
      t    = (mag & mask) * 60;
      mins = t >> FRAC_BITS;
      t    = (t & mask) * 60;
      secs = t >> FRAC_BITS;
      fr   = t & mask;
      if (fr * 2 >= ONE) begin
        secs++;
        if (secs == 60) begin
          secs = 0;
          mins++;
          if (mins == 60) begin
            mins = 0;
            deg++;
          end
        end
      end
      sdeg = neg ? -longint'(deg) : longint'(deg);
      r.whole_degrees = sdeg[DEG_W-1:0];
      r.arc_minutes   = mins[MIN_W-1:0];
      r.arc_seconds   = secs[SEC_W-1:0];
      r.is_negative   = neg;
      return r;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_angle(logic [ANGLE_W-1:0] angle);
      pending_dms.push_back(fold_and_split(angle));
      angles_noted++;
    endfunction

    task check_word(logic [M_TDATA_W-1:0] word);
      dms_t want;
      dms_t got;
      got.whole_degrees = word[8:0];
      got.arc_minutes   = word[14:9];
      got.arc_seconds   = word[20:15];
      got.is_negative   = word[21];
      if (pending_dms.size() == 0) begin
        report($sformatf("word %h with no angle pending", word));
      end else begin
        want = pending_dms.pop_front();
        words_checked++;
        if (got.whole_degrees !== want.whole_degrees)
          report($sformatf("word %0d degrees %0d, want %0d", words_checked,
                           got.whole_degrees, want.whole_degrees));
        if (got.arc_minutes !== want.arc_minutes)
          report($sformatf("word %0d minutes %0d, want %0d", words_checked,
                           got.arc_minutes, want.arc_minutes));
        if (got.arc_seconds !== want.arc_seconds)
          report($sformatf("word %0d seconds %0d, want %0d", words_checked,
                           got.arc_seconds, want.arc_seconds));
        if (got.is_negative !== want.is_negative)
          report($sformatf("word %0d sign %b, want %b", words_checked,
                           got.is_negative, want.is_negative));
        if (word[M_TDATA_W-1:22] !== '0)
          report($sformatf("word %0d pad bits %b", words_checked, word[M_TDATA_W-1:22]));
      end
    endtask
  endclass

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;   // angle
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;         // whole_degrees, arc_minutes, arc_seconds, is_negative

  dms_tracker tracker;
  bit         hold_wanted;
  int         long_holds;
  int         input_stalls;
  int         cycle_count;

  decimal_angle_to_dms #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (m_tvalid && m_tready) tracker.check_word(m_tdata);
      if (s_tvalid && !s_tready) input_stalls <= input_stalls + 1;
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // sink: modes of steady, patterned and random ready, plus long hold-offs
  initial begin : sink
    int mode;
    int span;
    int tick;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 80);
      for (tick = 0; tick < span; tick++) begin
        @(posedge clk);
        if (hold_wanted) begin
          hold_wanted = 1'b0;
          long_holds++;
          m_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= (tick % 4) != 3;
          2: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  task send_angle(logic [ANGLE_W-1:0] angle);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W-ANGLE_W){1'b0}}, angle};
    do @(posedge clk); while (!s_tready);
    tracker.note_angle(angle);
  endtask

  function automatic logic [ANGLE_W-1:0] pick_angle();
    bit [31:0] r;
    longint    v;
    r = $urandom();
    case ($urandom_range(0, 3))
      0, 1: v = longint'($signed(r[ANGLE_W-1:0]));
      // close to a multiple of a half turn
      2: v = (longint'($urandom_range(0, 10)) - 5) * HALF_TURN * ONE
             + longint'($urandom_range(0, 64)) - 32;
      // just under a whole degree, where seconds carry upward
      default: v = (longint'($urandom_range(0, 2046)) - 1023) * ONE + ONE
                   - longint'($urandom_range(1, 600));
    endcase
    return v[ANGLE_W-1:0];
  endfunction

  initial begin : source
    longint                directed[$];
    logic [ANGLE_W-1:0]    angles[$];
    int                    burst_left;
    int                    gap;
    tracker = new();

    directed = '{0, 1, -1, 1073741823, -1073741824,
                 180 * ONE, -180 * ONE, 540 * ONE, -540 * ONE,
                 -180 * ONE + 1, 180 * ONE - 1, ONE - 1, -(ONE - 1),
                 179 * ONE + ONE - 1, 360 * ONE, -360 * ONE,
                 90 * ONE + ONE / 2, ONE / 60, ONE / 3600, -(ONE / 7200),
                 longint'($signed(31'h2AAAAAAA)), longint'($signed(31'h55555555)), -50};
    foreach (directed[i]) angles.push_back(directed[i][ANGLE_W-1:0]);
    repeat (N_RANDOM) angles.push_back(pick_angle());

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    burst_left = $urandom_range(1, 12);
    foreach (angles[i]) begin
      if (i == 150 || i == 400) begin
        hold_wanted = 1'b1;
        burst_left  = 48;
      end
      send_angle(angles[i]);
      burst_left--;
      if (burst_left <= 0) begin
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
    end
    s_tvalid <= 1'b0;

    while (tracker.pending_dms.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("%0d angles sent (%0d directed), %0d words checked",
             tracker.angles_noted, directed.size(), tracker.words_checked);
    $display("%0d long sink hold-offs, %0d cycles with the input stalled",
             long_holds, input_stalls);
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
